// ===== sv/lpg_pkg.sv =====
// Package for the line pixel generator: command codes and fixed sizes.
// Depends on nothing; every other file of the block but lpg_if imports it.
package lpg_pkg;

    // Command codes carried in the opcode field
    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } lpg_op_t;

    // Depth of the command queue between front and back end
    localparam int QUEUE_DEPTH = 2;

endpackage

// ===== sv/lpg_if.sv =====
// Channel interfaces of the line pixel generator: command in, pixel out.
// Depends on nothing; the top level, lpg_front and lpg_back use them.
interface lpg_cmd_if #(parameter int COORD_BITS = 12);
    logic                         valid;
    logic                         ready;
    logic                         opcode;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] stop_x;
    logic signed [COORD_BITS-1:0] stop_y;

    modport source (output valid, opcode, start_x, start_y, stop_x, stop_y, input ready);
    modport sink   (input valid, opcode, start_x, start_y, stop_x, stop_y, output ready);
endinterface

interface lpg_pix_if #(parameter int COORD_BITS = 12);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last;

    modport source (output valid, pixel_x, pixel_y, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

// ===== sv/line_pixel_generator.sv =====
// Line pixel generator top level: front end, command queue and stepper.
// Path: a step command passes the front-end register, the queue and the pixel output register.
// Throughput: one command per cycle while the pixel output is not stalled; the error update of
// the stepper sets that figure, and the queue lets front and back stall on their own.
// Reset: no line running, queue and output register empty.
// Depends on lpg_pkg, lpg_if, lpg_front, lpg_queue and lpg_back.
module line_pixel_generator
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic      clk,
    input  logic      rst_n,
    lpg_cmd_if.sink   cmd,
    lpg_pix_if.source pix
);

    localparam int ENTRY_BITS = 5 * COORD_BITS + 3;

    logic                  push, full, pop, head_valid;
    logic [ENTRY_BITS-1:0] push_data, head_data;

    // Accept and classify commands
    lpg_front #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // Buffer prepared commands
    lpg_queue #(
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // Step the line and present pixels
    lpg_back #(
        .COORD_BITS (COORD_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .pix        (pix)
    );

endmodule

// ===== sv/lpg_front.sv =====
// Front end: accepts commands, classifies steep lines and prepares line setup.
// Depends on lpg_pkg and lpg_cmd_if; feeds lpg_queue.
module lpg_front
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int ENTRY_BITS = 5 * COORD_BITS + 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lpg_cmd_if.sink               cmd,
    output logic                  push,
    output logic [ENTRY_BITS-1:0] push_data,
    input  logic                  full
);

    localparam int CB = COORD_BITS;

    logic                 valid_reg;
    logic                 op_reg;
    logic                 steep_reg;
    logic signed [CB-1:0] a_maj_reg, a_min_reg, b_maj_reg, b_min_reg;

    logic signed [CB:0]   dx, dy;
    logic        [CB-1:0] adx, ady;
    logic                 steep_next;
    logic                 advance;

    // Spans of the two axes and the steepness decision
    always_comb
    begin
        dx = $signed({cmd.stop_x[CB-1], cmd.stop_x}) - $signed({cmd.start_x[CB-1], cmd.start_x});
        dy = $signed({cmd.stop_y[CB-1], cmd.stop_y}) - $signed({cmd.start_y[CB-1], cmd.start_y});
        adx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
        ady = dy[CB] ? CB'(-dy) : dy[CB-1:0];
        steep_next = ady > adx;
    end

    // Move on when the stage is empty or its item goes into the queue
    assign advance   = !valid_reg || !full;
    assign cmd.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= cmd.valid;
        end
    end

    // Hold the axis-ordered endpoints
    always_ff @(posedge clk)
    begin
        if (advance && cmd.valid)
        begin
            op_reg    <= cmd.opcode;
            steep_reg <= steep_next;
            a_maj_reg <= steep_next ? cmd.start_y : cmd.start_x;
            a_min_reg <= steep_next ? cmd.start_x : cmd.start_y;
            b_maj_reg <= steep_next ? cmd.stop_y  : cmd.stop_x;
            b_min_reg <= steep_next ? cmd.stop_x  : cmd.stop_y;
        end
    end

    // Order endpoints by major coordinate and derive spans and direction
    logic signed [CB:0]   d_maj, d_min;
    logic                 swap;
    logic        [CB-1:0] major_span, minor_span;
    logic signed [CB-1:0] major_pos, major_end, minor_pos;
    logic                 minor_dir;

    always_comb
    begin
        d_maj = $signed({b_maj_reg[CB-1], b_maj_reg}) - $signed({a_maj_reg[CB-1], a_maj_reg});
        d_min = $signed({b_min_reg[CB-1], b_min_reg}) - $signed({a_min_reg[CB-1], a_min_reg});
        swap  = d_maj[CB];
        major_span = swap ? CB'(-d_maj) : d_maj[CB-1:0];
        minor_span = d_min[CB] ? CB'(-d_min) : d_min[CB-1:0];
        major_pos  = swap ? b_maj_reg : a_maj_reg;
        major_end  = swap ? a_maj_reg : b_maj_reg;
        minor_pos  = swap ? b_min_reg : a_min_reg;
        // minus one unless the far end lies above the near end
        minor_dir  = swap ? !(d_min[CB] && (d_min != '0)) || (d_min == '0)
                          : (d_min[CB] || (d_min == '0));
    end

    assign push      = valid_reg && !full;
    assign push_data = {op_reg, steep_reg, major_pos, major_end, minor_pos, minor_dir,
                        major_span, minor_span};

endmodule

// ===== sv/lpg_queue.sv =====
// Short command queue that decouples the front end from the pixel stepper.
// Depends on lpg_pkg for its depth.
module lpg_queue
    import lpg_pkg::*;
#(
    parameter int WIDTH = 63
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_BITS'(push) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/lpg_back.sv =====
// Back end: runs the Bresenham stepper and holds the pixel output register.
// Depends on lpg_pkg and lpg_pix_if; takes commands from lpg_queue.
module lpg_back
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int ENTRY_BITS = 5 * COORD_BITS + 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  logic [ENTRY_BITS-1:0] head_data,
    output logic                  pop,
    lpg_pix_if.source             pix
);

    localparam int CB = COORD_BITS;

    // Unpack the queued command
    logic                 q_op;
    logic                 q_steep;
    logic signed [CB-1:0] q_major_pos, q_major_end, q_minor_pos;
    logic                 q_minor_dir;
    logic        [CB-1:0] q_major_span, q_minor_span;

    assign {q_op, q_steep, q_major_pos, q_major_end, q_minor_pos, q_minor_dir,
            q_major_span, q_minor_span} = head_data;

    logic                 active_reg, active_next;
    logic                 steep_reg;
    logic signed [CB-1:0] major_pos_reg, major_end_reg, minor_pos_reg;
    logic                 minor_dir_reg;
    logic        [CB-1:0] major_span_reg, minor_span_reg;
    logic signed [CB+1:0] err_reg;

    logic                 out_valid_reg, out_valid_next;
    logic signed [CB-1:0] out_x_reg, out_y_reg;
    logic                 out_last_reg;

    logic                 out_free;
    logic                 is_start, is_step, emit;
    logic                 last_pixel;
    logic signed [CB+1:0] err_sub, err_add, err_step;
    logic signed [CB-1:0] minor_step;

    // Take a command whenever the output register can receive a pixel
    assign out_free = !out_valid_reg || pix.ready;
    assign pop      = head_valid && out_free;
    assign is_start = pop && (q_op == OP_START);
    assign is_step  = pop && (q_op == OP_STEP);
    assign emit     = is_step && active_reg;

    // Error update and minor-axis move for one step
    always_comb
    begin
        last_pixel = (major_pos_reg + CB'(1)) == major_end_reg;
        err_sub    = err_reg - $signed({2'b00, minor_span_reg});
        err_add    = err_sub + $signed({2'b00, major_span_reg});
        err_step   = err_sub[CB+1] ? err_add : err_sub;
        minor_step = minor_dir_reg ? minor_pos_reg - CB'(1) : minor_pos_reg + CB'(1);
    end

    // Line-running flag: set by a start with nonzero span, cleared by a start with zero span or after the last pixel
    always_comb
    begin
        active_next = active_reg;
        if (is_start)
        begin
            active_next = (q_major_span != '0);
        end
        else if (emit && last_pixel)
        begin
            active_next = 1'b0;
        end
    end

    // Output register valid: fill on a pixel, drop once transferred
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load line state on a start, advance it on a step
    always_ff @(posedge clk)
    begin
        if (is_start)
        begin
            steep_reg      <= q_steep;
            major_pos_reg  <= q_major_pos;
            major_end_reg  <= q_major_end;
            minor_pos_reg  <= q_minor_pos;
            minor_dir_reg  <= q_minor_dir;
            major_span_reg <= q_major_span;
            minor_span_reg <= q_minor_span;
            err_reg        <= $signed({3'b000, q_major_span[CB-1:1]});
        end
        else if (emit)
        begin
            major_pos_reg <= major_pos_reg + CB'(1);
            err_reg       <= err_step;
            if (err_sub[CB+1])
            begin
                minor_pos_reg <= minor_step;
            end
        end
    end

    // Capture the pixel, swapping axes back for steep lines
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg    <= steep_reg ? minor_pos_reg : major_pos_reg;
            out_y_reg    <= steep_reg ? major_pos_reg : minor_pos_reg;
            out_last_reg <= last_pixel;
        end
    end

    assign pix.valid   = out_valid_reg;
    assign pix.pixel_x = out_x_reg;
    assign pix.pixel_y = out_y_reg;
    assign pix.last    = out_last_reg;

endmodule
